// File: sv/contiguous_ring_buffer_allocator_top_defines.svh
// assertion macros for the contiguous ring buffer allocator checker
`ifndef CONTIGUOUS_RING_BUFFER_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_RING_BUFFER_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define CRBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crba check failed");

// next-cycle implication, sampled on the rising clock edge
`define CRBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crba check failed");

`endif

// File: sv/crba_pkg.sv
// shared types and constants of the contiguous ring buffer allocator
package crba_pkg;

  localparam int COMMAND_W       = 2;
  localparam int WRITE_DATA_W    = 8;
  localparam int SLOT_INDEX_W    = 3;
  localparam int WRITE_ADDRESS_W = 8;
  localparam int ACTIVE_BASE_W   = 9;
  localparam int ACTIVE_BEATS_W  = 9;

  localparam logic [COMMAND_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_POP   = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_WRITE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [COMMAND_W-1:0]    command;
    logic [WRITE_DATA_W-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic                       status;
    logic [SLOT_INDEX_W-1:0]    slot_index;
    logic [WRITE_ADDRESS_W-1:0] write_address;
    logic [ACTIVE_BASE_W-1:0]   active_base;
    logic [ACTIVE_BEATS_W-1:0]  active_beats;
    logic                       incrementing;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic append;
    logic fail;
    logic pop_finish;
    logic move_start;
    logic copy_step;
    logic move_finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_slots;
    logic slots_full;
    logic store_full;
    logic needs_move;
    logic move_fits;
    logic copy_done;
  } sts_t;

endpackage

// File: sv/crba_ctrl.sv
// command sequencer of the contiguous ring buffer allocator
module crba_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [crba_pkg::COMMAND_W-1:0]     in_command,
  input  crba_pkg::sts_t                     sts,
  input  logic                               q_full,
  output crba_pkg::cmd_t                     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;
  localparam logic [1:0] ST_MFIN = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !q_full;
        if (in_valid && !q_full) begin
          unique case (in_command)
            crba_pkg::CMD_PUSH: begin
              if (sts.slots_full || sts.store_full) cmd.fail = 1'b1;
              else cmd.push = 1'b1;
            end
            crba_pkg::CMD_POP: begin
              if (sts.no_slots) cmd.fail = 1'b1;
              else state_nxt = ST_POP;
            end
            crba_pkg::CMD_WRITE: begin
              priority if (sts.no_slots || sts.store_full) begin
                cmd.fail = 1'b1;
              end else if (!sts.needs_move) begin
                cmd.append = 1'b1;
              end else if (sts.move_fits) begin
                cmd.move_start = 1'b1;
                state_nxt      = ST_COPY;
              end else begin
                cmd.fail = 1'b1;
              end
            end
            default: cmd.fail = 1'b1;
          endcase
        end
      end
      ST_POP: begin
        cmd.pop_finish = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) state_nxt = ST_MFIN;
      end
      ST_MFIN: begin
        cmd.move_finish = 1'b1;
        state_nxt       = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/crba_dp.sv
// slot table, beat store and bookkeeping registers of the allocator
module crba_dp #(
  parameter int POOL_BEATS  = 256,
  parameter int ALLOC_SLOTS = 8,
  parameter int BEAT_WIDTH  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crba_pkg::cmd_t                      cmd,
  input  logic [crba_pkg::WRITE_DATA_W-1:0]   write_data,
  output crba_pkg::sts_t                      sts,
  output logic                                res_valid,
  output crba_pkg::out_word_t                 res_data
);

  localparam int AW = (POOL_BEATS > 1) ? $clog2(POOL_BEATS) : 1;
  localparam int CW = $clog2(POOL_BEATS + 1);
  localparam int BW = CW + 1;
  localparam int SW = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
  localparam int UW = $clog2(ALLOC_SLOTS + 1);
  localparam int IDX_OW  = crba_pkg::SLOT_INDEX_W;
  localparam int ADDR_OW = crba_pkg::WRITE_ADDRESS_W;
  localparam int BASE_OW = crba_pkg::ACTIVE_BASE_W;
  localparam int CNT_OW  = crba_pkg::ACTIVE_BEATS_W;
  localparam logic [SW-1:0] SLOT_LAST = SW'(ALLOC_SLOTS - 1);

  // slot table
  logic [CW-1:0] slot_base_mem [ALLOC_SLOTS];
  logic [CW-1:0] slot_cnt_mem  [ALLOC_SLOTS];
  logic [CW-1:0] slot_pad_mem  [ALLOC_SLOTS];
  logic [CW-1:0] slot_base_rd_r;
  logic [CW-1:0] slot_cnt_rd_r;
  logic [CW-1:0] slot_pad_rd_r;

  // beat store
  logic [BEAT_WIDTH-1:0] beat_mem [POOL_BEATS];
  logic [BEAT_WIDTH-1:0] beat_rd_r;
  logic                  beat_we;
  logic [AW-1:0]         beat_wa;
  logic [BEAT_WIDTH-1:0] beat_wd;

  logic [UW-1:0] slots_used_r,  slots_used_nxt;
  logic [BW-1:0] beats_used_r,  beats_used_nxt;
  logic [SW-1:0] active_slot_r, active_slot_nxt;
  logic [SW-1:0] oldest_slot_r, oldest_slot_nxt;
  logic [CW-1:0] oldest_base_r, oldest_base_nxt;
  logic [CW-1:0] act_base_r,    act_base_nxt;
  logic [CW-1:0] act_cnt_r,     act_cnt_nxt;
  logic [CW-1:0] act_pad_r,     act_pad_nxt;

  // relocation
  logic [CW-1:0]         k_r;
  logic [CW-1:0]         move_pad_r;
  logic [BEAT_WIDTH-1:0] data_r;

  logic [SW-1:0] next_slot;
  logic [SW-1:0] next_oldest;
  logic [CW:0]   act_end;
  logic [CW:0]   freed;
  logic [CW-1:0] copy_src;
  logic [CW-1:0] k_m1;
  logic          slot_wr;
  logic [AW-1:0] res_addr;

  assign next_slot   = (active_slot_r == SLOT_LAST) ? '0 : active_slot_r + SW'(1);
  assign next_oldest = (oldest_slot_r == SLOT_LAST) ? '0 : oldest_slot_r + SW'(1);
  assign act_end     = {1'b0, act_base_r} + {1'b0, act_cnt_r};
  assign freed       = {1'b0, slot_cnt_rd_r} + {1'b0, slot_pad_rd_r};
  assign copy_src    = act_base_r + k_r;
  assign k_m1        = k_r - CW'(1);

  assign sts.no_slots   = (slots_used_r == '0);
  assign sts.slots_full = (slots_used_r >= UW'(ALLOC_SLOTS));
  assign sts.store_full = (beats_used_r >= BW'(POOL_BEATS));
  assign sts.needs_move = (act_end >= (CW + 1)'(POOL_BEATS));
  assign sts.move_fits  = (({1'b0, act_cnt_r} + (CW + 1)'(1)) <= {1'b0, oldest_base_r});
  assign sts.copy_done  = (k_r == act_cnt_r);

  always_comb begin
    slots_used_nxt  = slots_used_r;
    beats_used_nxt  = beats_used_r;
    active_slot_nxt = active_slot_r;
    oldest_slot_nxt = oldest_slot_r;
    oldest_base_nxt = oldest_base_r;
    act_base_nxt    = act_base_r;
    act_cnt_nxt     = act_cnt_r;
    act_pad_nxt     = act_pad_r;
    slot_wr         = 1'b0;
    res_addr        = '0;
    if (cmd.push) begin
      active_slot_nxt = next_slot;
      slots_used_nxt  = slots_used_r + UW'(1);
      if (slots_used_r == '0) begin
        act_base_nxt    = oldest_base_r;
        oldest_slot_nxt = next_slot;
      end else begin
        act_base_nxt = act_end[CW-1:0];
      end
      act_cnt_nxt = '0;
      act_pad_nxt = '0;
      slot_wr     = 1'b1;
    end
    if (cmd.append) begin
      act_cnt_nxt    = act_cnt_r + CW'(1);
      beats_used_nxt = beats_used_r + BW'(1);
      slot_wr        = 1'b1;
      res_addr       = act_end[AW-1:0];
    end
    if (cmd.pop_finish) begin
      slots_used_nxt = slots_used_r - UW'(1);
      beats_used_nxt = (freed > beats_used_r) ? '0 : beats_used_r - freed;
      if (slots_used_r != UW'(1)) begin
        oldest_slot_nxt = next_oldest;
        oldest_base_nxt = slot_base_rd_r;
      end
    end
    if (cmd.move_finish) begin
      act_base_nxt   = '0;
      act_cnt_nxt    = act_cnt_r + CW'(1);
      act_pad_nxt    = move_pad_r;
      beats_used_nxt = beats_used_r + {1'b0, move_pad_r} + BW'(1);
      slot_wr        = 1'b1;
      res_addr       = act_cnt_r[AW-1:0];
    end
  end

  always_comb begin
    beat_we = 1'b0;
    beat_wa = act_end[AW-1:0];
    beat_wd = BEAT_WIDTH'(write_data);
    if (cmd.copy_step && (k_r != '0)) begin
      beat_we = 1'b1;
      beat_wa = k_m1[AW-1:0];
      beat_wd = beat_rd_r;
    end else if (cmd.append) begin
      beat_we = 1'b1;
    end else if (cmd.move_finish) begin
      beat_we = 1'b1;
      beat_wa = act_cnt_r[AW-1:0];
      beat_wd = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r  <= '0;
      beats_used_r  <= '0;
      active_slot_r <= '0;
      oldest_slot_r <= '0;
      oldest_base_r <= '0;
      act_base_r    <= '0;
      act_cnt_r     <= '0;
      act_pad_r     <= '0;
    end else begin
      slots_used_r  <= slots_used_nxt;
      beats_used_r  <= beats_used_nxt;
      active_slot_r <= active_slot_nxt;
      oldest_slot_r <= oldest_slot_nxt;
      oldest_base_r <= oldest_base_nxt;
      act_base_r    <= act_base_nxt;
      act_cnt_r     <= act_cnt_nxt;
      act_pad_r     <= act_pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move_start) begin
      k_r        <= '0;
      move_pad_r <= CW'(POOL_BEATS) - act_base_r;
      data_r     <= BEAT_WIDTH'(write_data);
    end else if (cmd.copy_step) begin
      k_r <= k_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_wr) begin
      slot_base_mem[active_slot_nxt] <= act_base_nxt;
      slot_cnt_mem[active_slot_nxt]  <= act_cnt_nxt;
      slot_pad_mem[active_slot_nxt]  <= act_pad_nxt;
    end
    slot_cnt_rd_r  <= slot_cnt_mem[oldest_slot_r];
    slot_pad_rd_r  <= slot_pad_mem[oldest_slot_r];
    slot_base_rd_r <= slot_base_mem[next_oldest];
  end

  always_ff @(posedge clk) begin
    if (beat_we) beat_mem[beat_wa] <= beat_wd;
    beat_rd_r <= beat_mem[copy_src[AW-1:0]];
  end

  assign res_valid = cmd.push | cmd.append | cmd.fail | cmd.pop_finish | cmd.move_finish;

  always_comb begin
    res_data               = '0;
    res_data.status        = cmd.fail ? crba_pkg::STATUS_FAIL : crba_pkg::STATUS_OK;
    res_data.slot_index    = IDX_OW'(active_slot_nxt);
    res_data.write_address = ADDR_OW'(res_addr);
    if (slots_used_nxt != '0) begin
      res_data.active_base  = BASE_OW'(act_base_nxt);
      res_data.active_beats = CNT_OW'(act_cnt_nxt);
      res_data.incrementing = (act_cnt_nxt > CW'(1));
    end
  end

endmodule

// File: sv/crba_outq.sv
// two-word result queue between the allocator and its sink
module crba_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  crba_pkg::out_word_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output crba_pkg::out_word_t out_data
);

  crba_pkg::out_word_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: sv/contiguous_ring_buffer_allocator_top.sv
// top level of the contiguous ring buffer allocator
// A ring of ALLOC_SLOTS allocation slots over a circular store of POOL_BEATS
// beats, each slot one contiguous run. Every accepted word gives exactly one
// result word. Push, plain write and any failing command finish in the cycle
// they are accepted, so the next word may follow while the queue has room.
// Pop finishes in state ST_POP, since the freed size and the next base come
// out of the registered slot table read. A write that runs past the end of
// the store relocates the active slot to address 0: ST_COPY copies its beats,
// then ST_MFIN writes the new one; the beat store has one read and one write
// port and so copies one beat per cycle. Results go through a two-word queue,
// so new commands are taken while a result waits; in_ready drops only while a
// pop or a relocation is in progress or the queue is full. No clearing
// pass after reset: slot entries and beats are only ever read once written.
module contiguous_ring_buffer_allocator_top #(
  parameter int POOL_BEATS  = 256,
  parameter int ALLOC_SLOTS = 8,
  parameter int BEAT_WIDTH  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // command words
  input  logic                in_valid,
  output logic                in_ready,
  input  crba_pkg::in_word_t  in_data,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output crba_pkg::out_word_t out_data
);

  crba_pkg::cmd_t      cmd;
  crba_pkg::sts_t      sts;
  logic                q_full;
  logic                res_valid;
  crba_pkg::out_word_t res_data;

  // sequencer: decides each command from the datapath status
  crba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .sts        (sts),
    .q_full     (q_full),
    .cmd        (cmd)
  );

  // slot table, beat store and the result word
  crba_dp #(
    .POOL_BEATS  (POOL_BEATS),
    .ALLOC_SLOTS (ALLOC_SLOTS),
    .BEAT_WIDTH  (BEAT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .write_data (in_data.write_data),
    .sts        (sts),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  // result queue decouples the sink from the command side
  crba_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/crba_checker.sv
// port-level checks of the contiguous ring buffer allocator
`include "contiguous_ring_buffer_allocator_top_defines.svh"

module crba_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input crba_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input crba_pkg::out_word_t out_data
);

  // a stalled result word holds
  `CRBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // a push or an unknown command reports in the cycle after acceptance
  `CRBA_ASSERT_NEXT(a_fast_result, clk, rst_n, in_valid && in_ready && in_data.command != crba_pkg::CMD_POP && in_data.command != crba_pkg::CMD_WRITE, out_valid)

  // failed words never carry a write address
  `CRBA_ASSERT_IMPL(a_fail_addr, clk, rst_n, out_valid && out_data.status == crba_pkg::STATUS_FAIL, out_data.write_address == '0)

  // a nonzero write address only comes from a successful write
  `CRBA_ASSERT_IMPL(a_addr_ok, clk, rst_n, out_valid && out_data.write_address != '0, out_data.status == crba_pkg::STATUS_OK)

endmodule

bind contiguous_ring_buffer_allocator_top crba_checker u_crba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/crba_result_checker.sv
`timescale 1ns / 1ps
// result checker: predicts each result word of the allocator and compares it at the output
module crba_result_checker #(
  parameter int POOL_BEATS  = 256,
  parameter int ALLOC_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  crba_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  crba_pkg::out_word_t out_data,
  output int                  fail_count,
  output int unsigned         outstanding
);

  localparam int IDX_W   = crba_pkg::SLOT_INDEX_W;
  localparam int ADDR_W  = crba_pkg::WRITE_ADDRESS_W;
  localparam int BASE_W  = crba_pkg::ACTIVE_BASE_W;
  localparam int BEATS_W = crba_pkg::ACTIVE_BEATS_W;

  // predicted allocator state; beat contents never reach the result word
  int unsigned seg_base [ALLOC_SLOTS];
  int unsigned seg_len  [ALLOC_SLOTS];
  int unsigned seg_pad  [ALLOC_SLOTS];
  int unsigned fill_level;
  int unsigned open_count;
  int unsigned newest_seg;
  int unsigned oldest_seg;
  int unsigned oldest_start;

  crba_pkg::out_word_t predicted_results[$];

  function automatic crba_pkg::out_word_t allocate_step(input crba_pkg::in_word_t w);
    crba_pkg::out_word_t r;
    logic                ok;
    int unsigned         nxt, base, cnt, pad, freed, opened, addr;
    ok     = 1'b0;
    opened = 0;
    addr   = 0;
    case (w.command)
      crba_pkg::CMD_PUSH: begin
        if (open_count < ALLOC_SLOTS && fill_level < POOL_BEATS) begin
          nxt = (newest_seg + 1) % ALLOC_SLOTS;
          // first slot of an empty ring starts where the last popped one did
          if (open_count == 0) begin
            seg_base[nxt] = oldest_start;
            oldest_seg    = nxt;
          end else begin
            seg_base[nxt] = seg_base[newest_seg] + seg_len[newest_seg];
          end
          seg_len[nxt] = 0;
          seg_pad[nxt] = 0;
          open_count++;
          newest_seg = nxt;
          opened     = nxt;
          ok         = 1'b1;
        end
      end
      crba_pkg::CMD_POP: begin
        if (open_count != 0) begin
          open_count--;
          freed      = seg_len[oldest_seg] + seg_pad[oldest_seg];
          fill_level = (freed > fill_level) ? 0 : fill_level - freed;
          if (open_count > 0) begin
            oldest_seg   = (oldest_seg + 1) % ALLOC_SLOTS;
            oldest_start = seg_base[oldest_seg];
          end
          ok = 1'b1;
        end
      end
      crba_pkg::CMD_WRITE: begin
        if (open_count != 0 && fill_level < POOL_BEATS) begin
          base = seg_base[newest_seg];
          cnt  = seg_len[newest_seg];
          ok   = 1'b1;
          // run past the end of the store: relocate to 0, old tail span is padding
          if (base + cnt >= POOL_BEATS) begin
            pad = (base < POOL_BEATS) ? POOL_BEATS - base : 0;
            if (cnt + 1 > oldest_start) begin
              ok = 1'b0;
            end else begin
              seg_base[newest_seg] = 0;
              seg_pad[newest_seg]  = pad;
              fill_level += pad;
              base = 0;
            end
          end
          if (ok) begin
            addr = (base + cnt) % POOL_BEATS;
            seg_len[newest_seg] = cnt + 1;
            fill_level++;
          end
        end
      end
      default: begin
      end
    endcase
    r = '0;
    r.status        = ok ? crba_pkg::STATUS_OK : crba_pkg::STATUS_FAIL;
    r.slot_index    = IDX_W'((w.command == crba_pkg::CMD_PUSH && ok) ? opened : newest_seg);
    r.write_address = ADDR_W'((w.command == crba_pkg::CMD_WRITE && ok) ? addr : 0);
    if (open_count > 0) begin
      r.active_base  = BASE_W'(seg_base[newest_seg]);
      r.active_beats = BEATS_W'(seg_len[newest_seg]);
      r.incrementing = (seg_len[newest_seg] > 1);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    crba_pkg::out_word_t want;
    if (!rst_n) begin
      fill_level   = 0;
      open_count   = 0;
      newest_seg   = 0;
      oldest_seg   = 0;
      oldest_start = 0;
      predicted_results.delete();
    end else begin
      // input side first, in case a result leaves in the cycle its word enters
      if (in_valid && in_ready)
        predicted_results.push_back(allocate_step(in_data));
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result word %h", out_data);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
          check_field("write_address", 32'(want.write_address),
                      32'(out_data.write_address));
          check_field("active_base", 32'(want.active_base), 32'(out_data.active_base));
          check_field("active_beats", 32'(want.active_beats),
                      32'(out_data.active_beats));
          check_field("incrementing", 32'(want.incrementing),
                      32'(out_data.incrementing));
        end
      end
    end
    outstanding <= $unsigned(predicted_results.size());
  end

endmodule

// File: sim/contiguous_ring_buffer_allocator_top_tb.sv
`timescale 1ns / 1ps
// testbench top: command stimulus, idling phases, watchdog and verdict for the allocator
module contiguous_ring_buffer_allocator_top_tb;

  localparam int POOL_BEATS  = 256;
  localparam int ALLOC_SLOTS = 8;
  localparam int BEAT_WIDTH  = 8;
  localparam int DATA_W      = crba_pkg::WRITE_DATA_W;

  // command code the block must reject
  localparam logic [crba_pkg::COMMAND_W-1:0] CMD_UNUSED = 2'd3;

  // longest quiet stretch: a full-slot relocation plus long random stalls
  localparam int STALL_LIMIT  = 5000;
  // settle time after the last result, covers a relocation of a full store
  localparam int DRAIN_CYCLES = POOL_BEATS + 16;
  localparam int PHASE_WORDS  = 494;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  crba_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  crba_pkg::out_word_t out_data;

  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          quiet_cycles   = 0;
  int          fail_count;
  int unsigned outstanding;

  always #10 clk = ~clk;

  contiguous_ring_buffer_allocator_top #(
    .POOL_BEATS  (POOL_BEATS),
    .ALLOC_SLOTS (ALLOC_SLOTS),
    .BEAT_WIDTH  (BEAT_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  crba_result_checker #(
    .POOL_BEATS  (POOL_BEATS),
    .ALLOC_SLOTS (ALLOC_SLOTS)
  ) u_result_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // result sink: stalls at random per the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // watchdog on cycles where no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic crba_pkg::in_word_t make_word(
    input logic [crba_pkg::COMMAND_W-1:0] cmd,
    input logic [DATA_W-1:0]              data
  );
    crba_pkg::in_word_t w;
    w.command    = cmd;
    w.write_data = data;
    return w;
  endfunction

  // present one command word, optionally after random idle cycles, and hold it
  // until accepted; in_ready is sampled on the falling edge so it is settled
  task automatic send_word(input crba_pkg::in_word_t w);
    logic took;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // mostly allocations filled by runs of writes, with pops to free the ring so
  // slots wrap and relocate; rejected codes mixed in as noise
  task automatic send_random(input int count);
    int sent;
    int pick;
    int run;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_word(make_word(crba_pkg::CMD_PUSH, DATA_W'($urandom_range(0, 255))));
        sent++;
      end else if (pick < 24) begin
        send_word(make_word(crba_pkg::CMD_POP, DATA_W'($urandom_range(0, 255))));
        sent++;
      end else if (pick < 27) begin
        send_word(make_word(CMD_UNUSED, DATA_W'($urandom_range(0, 255))));
        sent++;
      end else begin
        run = $urandom_range(1, 24);
        repeat (run) begin
          send_word(make_word(crba_pkg::CMD_WRITE, DATA_W'($urandom_range(0, 255))));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejected code, pop and write on an empty ring
    send_word(make_word(CMD_UNUSED, 8'hAA));
    send_word(make_word(crba_pkg::CMD_POP, 8'h55));
    send_word(make_word(crba_pkg::CMD_WRITE, 8'h55));
    // fill every slot, the last push finds the ring full
    repeat (ALLOC_SLOTS + 1) send_word(make_word(crba_pkg::CMD_PUSH, 8'h00));
    // data extremes into the newest slot
    send_word(make_word(crba_pkg::CMD_WRITE, 8'h00));
    send_word(make_word(crba_pkg::CMD_WRITE, 8'hFF));
    // drain the ring, the last pop finds it empty
    repeat (ALLOC_SLOTS + 1) send_word(make_word(crba_pkg::CMD_POP, 8'hFF));
    // first push after emptying reuses the last oldest base
    send_word(make_word(crba_pkg::CMD_PUSH, 8'h0F));
    send_word(make_word(crba_pkg::CMD_WRITE, 8'hF0));

    // no idling
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_random(PHASE_WORDS);
    // sender mostly idle
    src_idle_pct   = 71;
    sink_stall_pct = 0;
    send_random(PHASE_WORDS);
    // receiver mostly stalled
    src_idle_pct   = 0;
    sink_stall_pct = 71;
    send_random(PHASE_WORDS);
    // both sides idle now and then
    src_idle_pct   = 22;
    sink_stall_pct = 22;
    send_random(PHASE_WORDS);

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
